### rtl/ctm_pkg.sv
`timescale 1ns / 1ps
// ctm_pkg: shared types, widths, constants and the chord shape table
// for the chord template matcher; depends on nothing

package ctm_pkg;

    localparam int CONF_W             = 17;
    localparam int ROOT_W             = 4;
    localparam int QUAL_W             = 5;
    localparam int PC_W               = 12;
    localparam int NUM_ROOTS          = 12;
    localparam int MAX_TEMPLATES      = 32;
    localparam int NUM_W              = 5;
    localparam int DEN_W              = 8;
    localparam int CNT_W              = 4;
    localparam int IN_TDATA_W         = 16;
    localparam int OUT_TDATA_W        = 32;
    localparam int APB_ADDR_W         = 3;
    localparam int APB_DATA_W         = 32;
    localparam int CONF_FRAC_BITS_DEF = 16;
    localparam int TEMPLATE_COUNT_DEF = 32;

    localparam logic [CONF_W-1:0] SMOOTH_RESET = CONF_W'(19661);

    localparam logic REG_SMOOTH  = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    localparam logic [PC_W-1:0] CHORD_SHAPES [MAX_TEMPLATES] = '{
        12'h091, 12'h089, 12'h049, 12'h111,
        12'h491, 12'h891, 12'h489, 12'h449, 12'h249, 12'h889,
        12'h495, 12'h895, 12'h48D, 12'hC95, 12'h695, 12'h895,
        12'h085, 12'h0A1, 12'h485, 12'h4A1,
        12'h095, 12'h0B1, 12'h291, 12'h08D,
        12'h493, 12'h499, 12'h4D1, 12'h511, 12'h453, 12'h459,
        12'h081, 12'h001
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_MUL_NEW,
        ST_MUL_HELD,
        ST_DONE
    } ctm_state_t;

endpackage

### rtl/chord_template_matcher_core.sv
`timescale 1ns / 1ps
// chord_template_matcher_core: chord recognition by template matching over
// all roots, exact best-score search, iterative divide and smoothing
// depends on ctm_pkg
//
// channel  direction  beat contents (low bit first)
// s_       in         tdata: pitch_set[11:0], pad; tuser: func
// m_       out        tdata: chord_root[3:0], chord_quality[8:4],
//                     confidence[25:9], pad
// apb      in/out     smoothing_factor at byte address 0
//
// an item passes from accept through the scan, a drain step, the divider
// and, in update mode with a nonzero held confidence, two multiply steps
// before the next ready; one root/template pair is scored per cycle, then a
// restoring divider yields one quotient bit per cycle, then a shared
// multiplier does the two smoothing products
// s_tready is high only while idle; a finished beat waits in the output
// register, and the block stalls only if a second result is ready before it
// reset is synchronous and active low; no clearing pass is needed

module chord_template_matcher_core
    import ctm_pkg::*;
#(
    parameter int CONF_FRAC_BITS = CONF_FRAC_BITS_DEF,
    parameter int TEMPLATE_COUNT = TEMPLATE_COUNT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // pitch_set[11:0], zero pad
    input  logic                   s_tuser,   // func

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // chord_root, chord_quality, confidence, pad

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int XW   = CONF_FRAC_BITS + 1;
    localparam int WW   = (XW > CONF_W) ? XW : CONF_W;
    localparam int DW   = NUM_W + CONF_FRAC_BITS;
    localparam int DCW  = $clog2(DW);
    localparam int PW   = XW + CONF_W;
    localparam int ACCW = PW + 1;
    localparam int PRODW = NUM_W + DEN_W;

    localparam logic [WW-1:0]     ONE_W     = WW'(1) << CONF_FRAC_BITS;
    localparam logic [QUAL_W-1:0] TMPL_LAST = QUAL_W'(TEMPLATE_COUNT - 1);
    localparam logic [ROOT_W-1:0] ROOT_LAST = ROOT_W'(NUM_ROOTS - 1);
    localparam logic [DCW-1:0]    DIV_LAST  = DCW'(DW - 1);

    ctm_state_t state_reg, state_next;

    logic                 func_reg, func_next;
    logic [PC_W-1:0]      rot_reg, rot_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic [QUAL_W-1:0]    tmpl_reg, tmpl_next;

    logic                 p_vld_reg, p_vld_next;
    logic [NUM_W-1:0]     p_num_reg, p_num_next;
    logic [DEN_W-1:0]     p_den_reg, p_den_next;
    logic [ROOT_W-1:0]    p_root_reg, p_root_next;
    logic [QUAL_W-1:0]    p_q_reg, p_q_next;

    logic [NUM_W-1:0]     best_num_reg, best_num_next;
    logic [DEN_W-1:0]     best_den_reg, best_den_next;
    logic [ROOT_W-1:0]    best_root_reg, best_root_next;
    logic [QUAL_W-1:0]    best_q_reg, best_q_next;

    logic [DEN_W-1:0]     div_rem_reg, div_rem_next;
    logic [DW-1:0]        div_quo_reg, div_quo_next;
    logic [DCW-1:0]       div_cnt_reg, div_cnt_next;

    logic [ACCW-1:0]      acc_reg, acc_next;
    logic [WW-1:0]        conf_reg, conf_next;
    logic [CONF_W-1:0]    held_reg, held_next;
    logic [CONF_W-1:0]    smooth_reg, smooth_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [ROOT_W-1:0]    out_root_reg, out_root_next;
    logic [QUAL_W-1:0]    out_q_reg, out_q_next;
    logic [CONF_W-1:0]    out_conf_reg, out_conf_next;

    logic                 in_accept;
    logic                 out_load;
    logic                 scan_last;
    logic                 cfg_write;

    logic [PC_W-1:0]      shape;
    logic [3:0]           sc_m;
    logic [3:0]           sc_r;
    logic [3:0]           sc_e2;
    logic [NUM_W-1:0]     sc_num;
    logic [DEN_W-1:0]     sc_den;
    logic [PRODW-1:0]     cmp_lhs;
    logic [PRODW-1:0]     cmp_rhs;
    logic                 better;

    logic [DEN_W:0]       div_trial;
    logic                 div_bit;

    logic [WW-1:0]        a_w;
    logic [WW-1:0]        one_minus_a_w;
    logic [XW-1:0]        mul_x;
    logic [CONF_W-1:0]    mul_y;
    logic [PW-1:0]        prod;
    logic [ACCW-1:0]      mac_sum;

    logic [WW-1:0]        cfg_v;

    // control outputs
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        in_accept = s_tvalid && s_tready;
        out_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
        scan_last = (root_reg == ROOT_LAST) && (tmpl_reg == TMPL_LAST);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_cnt_reg == '0) begin
                    if (func_reg == FUNC_UPDATE && held_reg != '0) begin
                        state_next = ST_MUL_NEW;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL_NEW: begin
                state_next = ST_MUL_HELD;
            end
            ST_MUL_HELD: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // pair scoring
    always_comb begin
        shape   = CHORD_SHAPES[tmpl_reg];
        sc_m    = 4'($countones(rot_reg & shape));
        sc_r    = 4'($countones(shape));
        sc_e2   = 4'($countones(rot_reg & ~shape)) + 4'd2;
        sc_num  = {sc_m, 1'b0};
        sc_den  = DEN_W'(sc_r) * DEN_W'(sc_e2);
        cmp_lhs = PRODW'(p_num_reg) * PRODW'(best_den_reg);
        cmp_rhs = PRODW'(best_num_reg) * PRODW'(p_den_reg);
        better  = p_vld_reg && (cmp_lhs > cmp_rhs);
    end

    // divider step and shared multiplier
    always_comb begin
        div_trial     = {div_rem_reg, div_quo_reg[DW-1]};
        div_bit       = (div_trial >= {1'b0, best_den_reg});
        a_w           = WW'(smooth_reg);
        one_minus_a_w = ONE_W - a_w;
        if (state_reg == ST_MUL_NEW) begin
            mul_x = conf_reg[XW-1:0];
            mul_y = smooth_reg;
        end else begin
            mul_x = one_minus_a_w[XW-1:0];
            mul_y = held_reg;
        end
        prod    = PW'(mul_x) * PW'(mul_y);
        mac_sum = acc_reg + ACCW'(prod);
    end

    // register file
    always_comb begin
        pready      = 1'b1;
        cfg_write   = psel && penable && pwrite && pready;
        cfg_v       = WW'(pwdata[CONF_W-1:0]);
        smooth_next = smooth_reg;
        if (cfg_write && paddr[APB_ADDR_W-1:2] == REG_SMOOTH) begin
            smooth_next = (cfg_v > ONE_W) ? ONE_W[CONF_W-1:0] : cfg_v[CONF_W-1:0];
        end
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_SMOOTH) begin
            prdata = APB_DATA_W'(smooth_reg);
        end
    end

    // datapath next values
    always_comb begin
        func_next      = func_reg;
        rot_next       = rot_reg;
        root_next      = root_reg;
        tmpl_next      = tmpl_reg;
        p_vld_next     = 1'b0;
        p_num_next     = sc_num;
        p_den_next     = sc_den;
        p_root_next    = root_reg;
        p_q_next       = tmpl_reg;
        best_num_next  = best_num_reg;
        best_den_next  = best_den_reg;
        best_root_next = best_root_reg;
        best_q_next    = best_q_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_cnt_next   = div_cnt_reg;
        acc_next       = acc_reg;
        conf_next      = conf_reg;
        held_next      = held_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_root_next  = out_root_reg;
        out_q_next     = out_q_reg;
        out_conf_next  = out_conf_reg;

        if (better) begin
            best_num_next  = p_num_reg;
            best_den_next  = p_den_reg;
            best_root_next = p_root_reg;
            best_q_next    = p_q_reg;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    func_next      = s_tuser;
                    rot_next       = s_tdata[PC_W-1:0];
                    root_next      = '0;
                    tmpl_next      = '0;
                    best_num_next  = '0;
                    best_den_next  = DEN_W'(1);
                    best_root_next = '0;
                    best_q_next    = '0;
                end
            end
            ST_SCAN: begin
                p_vld_next = (sc_den != '0);
                if (tmpl_reg == TMPL_LAST) begin
                    tmpl_next = '0;
                    root_next = root_reg + ROOT_W'(1);
                    rot_next  = {rot_reg[0], rot_reg[PC_W-1:1]};
                end else begin
                    tmpl_next = tmpl_reg + QUAL_W'(1);
                end
            end
            ST_DRAIN: begin
                div_rem_next = '0;
                div_quo_next = DW'(best_num_next) << CONF_FRAC_BITS;
                div_cnt_next = DIV_LAST;
            end
            ST_DIV: begin
                div_rem_next = div_bit ? DEN_W'(div_trial - {1'b0, best_den_reg})
                                       : div_trial[DEN_W-1:0];
                div_quo_next = {div_quo_reg[DW-2:0], div_bit};
                div_cnt_next = div_cnt_reg - DCW'(1);
                if (div_cnt_reg == '0) begin
                    conf_next = WW'(div_quo_next[XW-1:0]);
                end
            end
            ST_MUL_NEW: begin
                acc_next = ACCW'(prod);
            end
            ST_MUL_HELD: begin
                conf_next = WW'(mac_sum >> CONF_FRAC_BITS);
            end
            ST_DONE: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    out_root_next = best_root_reg;
                    out_q_next    = best_q_reg;
                    out_conf_next = conf_reg[CONF_W-1:0];
                    if (func_reg == FUNC_UPDATE) begin
                        held_next = conf_reg[CONF_W-1:0];
                    end
                end
            end
            default: begin
                p_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            p_vld_reg    <= 1'b0;
            held_reg     <= '0;
            smooth_reg   <= SMOOTH_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            p_vld_reg    <= p_vld_next;
            held_reg     <= held_next;
            smooth_reg   <= smooth_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        rot_reg       <= rot_next;
        root_reg      <= root_next;
        tmpl_reg      <= tmpl_next;
        p_num_reg     <= p_num_next;
        p_den_reg     <= p_den_next;
        p_root_reg    <= p_root_next;
        p_q_reg       <= p_q_next;
        best_num_reg  <= best_num_next;
        best_den_reg  <= best_den_next;
        best_root_reg <= best_root_next;
        best_q_reg    <= best_q_next;
        div_rem_reg   <= div_rem_next;
        div_quo_reg   <= div_quo_next;
        div_cnt_reg   <= div_cnt_next;
        acc_reg       <= acc_next;
        conf_reg      <= conf_next;
        out_root_reg  <= out_root_next;
        out_q_reg     <= out_q_next;
        out_conf_reg  <= out_conf_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_conf_reg, out_q_reg, out_root_reg});

`ifndef SYNTH
    // root index never leaves the octave while scanning
    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (root_reg <= ROOT_LAST))
        else $error("root index out of range");

    // best score never exceeds one
    a_best_le_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV || state_reg == ST_DONE) |->
        ({3'b000, best_num_reg} <= best_den_reg))
        else $error("best score above one");

    // unsmoothed confidence is at most one
    a_conf_le_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && func_reg != FUNC_UPDATE) |-> (conf_reg <= ONE_W))
        else $error("confidence above one");

    // no scored pair is left in flight while idle
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !p_vld_reg)
        else $error("scoring stage busy while idle");

    // held confidence only changes when an update result is delivered
    a_held_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(held_reg)) |->
        $past(out_load && func_reg == FUNC_UPDATE))
        else $error("held confidence changed outside an update");
`endif

endmodule
